FILE: rtl/tds_pkg.sv
// Shared types and constants of the TDS excitation and measurement block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tds_pkg;

  localparam int unsigned CHANNELS = 2;
  localparam logic [1:0] ALL_MASK = 2'(( 1 << CHANNELS) - 1);

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_STOP    = 2'd1;
  localparam logic [1:0] ACT_MEASURE = 2'd2;

  localparam logic [2:0] REG_FULL_SCALE = 3'd0;
  localparam logic [2:0] REG_REF_RES    = 3'd1;
  localparam logic [2:0] REG_ELEC_RES   = 3'd2;
  localparam logic [2:0] REG_TEMP_COEF  = 3'd3;
  localparam logic [2:0] REG_TDS_FACTOR = 3'd4;
  localparam logic [2:0] REG_VALUE_MAX  = 3'd5;
  localparam logic [2:0] REG_VALUE_MIN  = 3'd6;
  localparam logic [2:0] REG_TOGGLE     = 3'd7;

  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_POS  = 2'd1;
  localparam logic [1:0] SP_NEG  = 2'd2;

  localparam logic [27:0] COND_NUM_Q8 = 28'd256000000;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  channel_mask;
    logic [15:0] pos_sample;
    logic [15:0] neg_sample;
    logic [7:0]  temperature;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  drive_pos;
    logic [1:0]  drive_neg;
    logic [1:0]  started_mask;
    logic [1:0]  sample_point;
    logic [15:0] tds_value;
  } out_word_t;

endpackage
`default_nettype wire

FILE: rtl/tds_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on tds_pkg for the word types.
`timescale 1ns / 1ps
`default_nettype none
interface tds_in_if import tds_pkg::*; ;
  logic     valid;
  logic     ready;
  in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface tds_out_if import tds_pkg::*; ;
  logic      valid;
  logic      ready;
  out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

FILE: rtl/tds_excitation_and_measure.sv
// Top level: excitation sequencer for the probe pins and TDS measurement.
// Depends on tds_pkg and the channel interfaces in tds_if.sv.
//
//  channel   dir  handshake           payload
//  in_ch     in   valid/ready         action, mask, samples, temperature
//  out_ch    out  valid/ready         pins, run mask, sample point, tds value
//  cfg       in   cfg_we_i            cfg_idx_i, cfg_data_i
//
// Tick, stop and unused words go straight into the output register on acceptance.
// A measure of a running channel is worked out phase by phase after acceptance:
// one shared 84-bit adder/subtractor runs shift-add multiplies, restoring divides and
// the square root one bit (root: two radicand bits) per cycle.
// Reset clears pins, flags, counter and configuration registers to their defaults.
// in_ch.ready is low while a measure runs or a result waits unaccepted.
`timescale 1ns / 1ps
`default_nettype none
module tds_excitation_and_measure import tds_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  tds_in_if.sink           in_ch,
  tds_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef enum logic [7:0] {
    PH_NUM   = 8'b0000_0001,
    PH_RP    = 8'b0000_0010,
    PH_RN    = 8'b0000_0100,
    PH_PROD  = 8'b0000_1000,
    PH_ROOT  = 8'b0001_0000,
    PH_COND  = 8'b0010_0000,
    PH_COMP  = 8'b0100_0000,
    PH_SCALE = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_e;

  // configuration
  logic [15:0] full_scale_q, temp_coef_q, tds_factor_q, value_max_q, value_min_q;
  logic [23:0] ref_res_q, elec_res_q;
  logic [7:0]  toggle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= 16'd4095;
      ref_res_q    <= 24'd1000;
      elec_res_q   <= 24'd0;
      temp_coef_q  <= 16'd1311;
      tds_factor_q <= 16'd32768;
      value_max_q  <= 16'd999;
      value_min_q  <= 16'd0;
      toggle_q     <= 8'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FULL_SCALE: full_scale_q <= cfg_data_i[15:0];
        REG_REF_RES:    ref_res_q    <= cfg_data_i;
        REG_ELEC_RES:   elec_res_q   <= cfg_data_i;
        REG_TEMP_COEF:  temp_coef_q  <= cfg_data_i[15:0];
        REG_TDS_FACTOR: tds_factor_q <= cfg_data_i[15:0];
        REG_VALUE_MAX:  value_max_q  <= cfg_data_i[15:0];
        REG_VALUE_MIN:  value_min_q  <= cfg_data_i[15:0];
        REG_TOGGLE:     toggle_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  op_e    op_q, op_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [83:0] x_q, x_d, y_q, y_d, acc_q, acc_d, r_q, r_d;
  logic [39:0] num_q, num_d;
  logic [40:0] rp_q, rp_d, rn_q, rn_d;
  logic [15:0] pos_q, pos_d, neg_q, neg_d;
  logic [7:0]  temp_q, temp_d;

  logic [7:0]          tick_q, tick_d;
  logic [CHANNELS-1:0] run_q, run_d, phase_fl_q, phase_fl_d, pp_q, pp_d, pn_q, pn_d;
  logic                ov_q, ov_d;
  out_word_t           ow_q, ow_d;

  // shared adder/subtractor
  logic [83:0] ua, ub, rem_sh;
  logic        sub;
  logic [84:0] sum;

  always_comb begin
    rem_sh = (op_q == OP_SQRT) ? {acc_q[81:0], y_q[83:82]} : {acc_q[82:0], y_q[83]};
    if (op_q == OP_MUL) begin
      ua  = acc_q;
      ub  = x_q;
      sub = 1'b0;
    end else begin
      ua  = rem_sh;
      ub  = (op_q == OP_SQRT) ? {r_q[81:0], 2'b01} : x_q;
      sub = 1'b1;
    end
    sum = {1'b0, ua} + {1'b0, (sub ? ~ub : ub)} + {84'd0, sub};
  end

  // helpers
  logic [15:0] pos_c, neg_c, drop_p, drop_n;
  logic [41:0] r_signed;
  logic [40:0] r_abs;
  logic signed [27:0] k_s;
  logic [35:0] raw;
  logic [15:0] clamp;

  always_comb begin
    pos_c    = (pos_q > full_scale_q) ? full_scale_q : pos_q;
    neg_c    = (neg_q > full_scale_q) ? full_scale_q : neg_q;
    drop_p   = full_scale_q - pos_c;
    drop_n   = neg_c;
    r_signed = {2'b00, r_q[39:0]} - {18'd0, elec_res_q};
    r_abs    = r_signed[41] ? 41'(-r_signed) : r_signed[40:0];
    k_s      = 28'sd65536 + $signed({12'd0, temp_coef_q}) *
               ($signed({20'd0, temp_q}) - 28'sd25);
    raw      = acc_q[59:24];
    clamp    = (raw >= {20'd0, value_max_q}) ? value_max_q : raw[15:0];
    if (clamp <= value_min_q) clamp = value_min_q;
  end

  // input word decode
  in_word_t            iw;
  logic                acc_in, any_ok, single_ok;
  logic [$clog2(CHANNELS+1)-1:0] low_idx;
  logic [7:0]          tick_inc;

  assign in_ch.ready = (state_q == S_IDLE) && (!ov_q || out_ch.ready);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov_q;
  assign out_ch.word  = ow_q;

  always_comb begin
    iw        = in_ch.word;
    any_ok    = (iw.channel_mask != 2'd0) && (iw.channel_mask <= ALL_MASK);
    single_ok = (iw.channel_mask != 2'd0) && (iw.channel_mask < ALL_MASK);
    low_idx   = ($clog2(CHANNELS+1))'(CHANNELS);
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (iw.channel_mask[i]) low_idx = ($clog2(CHANNELS+1))'(i);
    end
    tick_inc = tick_q + 8'd1;
  end

  always_comb begin
    state_d = state_q;  phase_d = phase_q;  op_d = op_q;  cnt_d = cnt_q;
    x_d = x_q;  y_d = y_q;  acc_d = acc_q;  r_d = r_q;
    num_d = num_q;  rp_d = rp_q;  rn_d = rn_q;
    pos_d = pos_q;  neg_d = neg_q;  temp_d = temp_q;
    tick_d = tick_q;  run_d = run_q;  phase_fl_d = phase_fl_q;
    pp_d = pp_q;  pn_d = pn_q;
    ov_d = ov_q && !out_ch.ready;
    ow_d = ow_q;

    case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          if (iw.action == ACT_TICK && any_ok) begin
            tick_d = tick_inc;
            if (tick_inc >= toggle_q) begin
              tick_d = 8'd0;
              for (int i = 0; i < CHANNELS; i++) begin
                if (iw.channel_mask[i]) begin
                  if (!run_q[i]) begin
                    pp_d[i] = 1'b1;  pn_d[i] = 1'b0;
                    run_d[i] = 1'b1; phase_fl_d[i] = 1'b1;
                  end else begin
                    pp_d[i] = !pp_q[i];  pn_d[i] = !pn_q[i];
                    phase_fl_d[i] = !phase_fl_q[i];
                  end
                end
              end
            end
          end else if (iw.action == ACT_STOP && any_ok) begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (iw.channel_mask[i]) begin
                pp_d[i] = 1'b0;  pn_d[i] = 1'b0;
                run_d[i] = 1'b0; phase_fl_d[i] = 1'b0;
              end
            end
            tick_d = 8'd0;
          end
          ow_d.drive_pos    = pp_d;
          ow_d.drive_neg    = pn_d;
          ow_d.started_mask = run_d;
          ow_d.sample_point = SP_NONE;
          if (single_ok && tick_d == {1'b0, toggle_q[7:1]} && low_idx < CHANNELS) begin
            ow_d.sample_point = phase_fl_d[low_idx[$clog2(CHANNELS)-1:0]] ? SP_POS : SP_NEG;
          end
          ow_d.tds_value = 16'd0;
          ov_d = 1'b1;
          if (iw.action == ACT_MEASURE) begin
            ow_d.tds_value = value_min_q;
            if (single_ok && low_idx < CHANNELS &&
                run_q[low_idx[$clog2(CHANNELS)-1:0]]) begin
              ov_d    = 1'b0;
              pos_d   = iw.pos_sample;
              neg_d   = iw.neg_sample;
              temp_d  = iw.temperature;
              phase_d = PH_NUM;
              state_d = S_LOAD;
            end
          end
        end
      end

      S_LOAD: begin
        acc_d   = 84'd0;
        r_d     = 84'd0;
        state_d = S_RUN;
        case (phase_q)
          PH_NUM: begin
            op_d = OP_MUL;  cnt_d = 7'd24;
            x_d  = {68'd0, full_scale_q};
            y_d  = {60'd0, ref_res_q};
          end
          PH_RP: begin
            if (drop_p == 16'd0) begin
              rp_d = 41'd0;
              phase_d = PH_RN;
              state_d = S_LOAD;
            end else begin
              op_d = OP_DIV;  cnt_d = 7'd40;
              x_d  = {68'd0, drop_p};
              y_d  = {num_q, 44'd0};
            end
          end
          PH_RN: begin
            if (drop_n == 16'd0) begin
              rn_d = 41'd0;
              phase_d = PH_PROD;
              state_d = S_LOAD;
            end else begin
              op_d = OP_DIV;  cnt_d = 7'd40;
              x_d  = {68'd0, drop_n};
              y_d  = {num_q, 44'd0};
            end
          end
          PH_PROD: begin
            op_d = OP_MUL;  cnt_d = 7'd41;
            x_d  = {43'd0, rp_q};
            y_d  = {43'd0, rn_q};
          end
          PH_ROOT: begin
            op_d = OP_SQRT;  cnt_d = 7'd41;
            y_d  = {acc_q[81:0], 2'b00};
          end
          PH_COND: begin
            if (r_q[40:0] == 41'd0) begin
              phase_d = PH_COMP;
              state_d = S_LOAD;
            end else begin
              op_d = OP_DIV;  cnt_d = 7'd28;
              x_d  = {43'd0, r_q[40:0]};
              y_d  = {COND_NUM_Q8, 56'd0};
            end
          end
          PH_COMP: begin
            if (k_s <= 28'sd0) begin
              ow_d.tds_value = (value_min_q > 16'd0) ? value_min_q : 16'd0;
              ov_d    = 1'b1;
              state_d = S_IDLE;
            end else begin
              op_d = OP_DIV;  cnt_d = 7'd44;
              x_d  = {57'd0, k_s[26:0]};
              y_d  = {r_q[27:0], 56'd0};
            end
          end
          PH_SCALE: begin
            op_d = OP_MUL;  cnt_d = 7'd16;
            x_d  = {40'd0, r_q[43:0]};
            y_d  = {68'd0, tds_factor_q};
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_RUN: begin
        case (op_q)
          OP_MUL: begin
            if (y_q[0]) acc_d = sum[83:0];
            x_d = {x_q[82:0], 1'b0};
            y_d = {1'b0, y_q[83:1]};
          end
          OP_SQRT: begin
            y_d = {y_q[81:0], 2'b00};
            if (sum[84]) begin
              acc_d = sum[83:0];  r_d = {r_q[82:0], 1'b1};
            end else begin
              acc_d = rem_sh;     r_d = {r_q[82:0], 1'b0};
            end
          end
          default: begin
            y_d = {y_q[82:0], 1'b0};
            if (sum[84]) begin
              acc_d = sum[83:0];  r_d = {r_q[82:0], 1'b1};
            end else begin
              acc_d = rem_sh;     r_d = {r_q[82:0], 1'b0};
            end
          end
        endcase
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) state_d = S_DONE;
      end

      S_DONE: begin
        state_d = S_LOAD;
        case (phase_q)
          PH_NUM:   begin num_d = acc_q[39:0]; phase_d = PH_RP;   end
          PH_RP:    begin rp_d = r_abs;        phase_d = PH_RN;   end
          PH_RN:    begin rn_d = r_abs;        phase_d = PH_PROD; end
          PH_PROD:  phase_d = PH_ROOT;
          PH_ROOT:  phase_d = PH_COND;
          PH_COND:  phase_d = PH_COMP;
          PH_COMP:  phase_d = PH_SCALE;
          PH_SCALE: begin
            ow_d.tds_value = clamp;
            ov_d    = 1'b1;
            state_d = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_NUM;
      cnt_q      <= 7'd0;
      tick_q     <= 8'd0;
      run_q      <= '0;
      phase_fl_q <= '0;
      pp_q       <= '0;
      pn_q       <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      tick_q     <= tick_d;
      run_q      <= run_d;
      phase_fl_q <= phase_fl_d;
      pp_q       <= pp_d;
      pn_q       <= pn_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    x_q    <= x_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
    r_q    <= r_d;
    num_q  <= num_d;
    rp_q   <= rp_d;
    rn_q   <= rn_d;
    pos_q  <= pos_d;
    neg_q  <= neg_d;
    temp_q <= temp_d;
    ow_q   <= ow_d;
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && in_ch.word.action != ACT_MEASURE) |=> out_ch.valid)
    else $error("missing result word");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (cnt_q != 7'd0 && cnt_q <= 7'd44))
    else $error("step count out of range");

endmodule
`default_nettype wire
